>>> hdl/lz_phrase_random_access_macros.svh
// Assertion macros for the phrase random access block.
// Used by the checker module only.
`ifndef LZ_PHRASE_RANDOM_ACCESS_MACROS_SVH
`define LZ_PHRASE_RANDOM_ACCESS_MACROS_SVH
// Implication checked on every rising edge, reset excluded.
`define LZPRA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every rising edge, reset excluded.
`define LZPRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hdl/lzpra_pkg.sv
// Package for the phrase random access block: sizes, codes and control structs.
// No dependencies.
package lzpra_pkg;
    localparam int MaxPhrases = 4096;
    localparam int PosBits    = 24;
    localparam int MaxHops    = 65535;
    localparam int HopBits    = 16;
    localparam int CharBits   = 8;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_HOPLIM   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic take_in;     // capture input item
        logic do_clear;
        logic do_load;     // commit load (write tables, bump count)
        logic srch_init;   // start a search at current pos
        logic rd_mid;      // issue read at mid
        logic step_mid;    // update low/high/res/found from end read
        logic rd_res;      // issue read at res
        logic rd_prev;     // issue read at res-1
        logic cap_res;     // capture end/src/char of res
        logic cap_prev;    // capture end of res-1
        logic do_hop;      // pos <= source + offset, hops++
        logic set_out;     // load output register
        logic [1:0] out_st;
        logic out_char;    // use found char
        logic out_hmax;    // hops reported as limit
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic full;        // table full
        logic load_ovf;    // accumulated end overflows
        logic srch_more;   // low < high
        logic found;
        logic res_valid;   // res < count
        logic res_zero;
        logic hit;         // pos == this_end
        logic in_phrase;   // prev_end < pos < this_end
        logic hop_lim;
        logic hop_ovf;     // jump target out of range
    } t_sts;
endpackage

>>> hdl/lzpra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lzpra_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> hdl/lzpra_dp.sv
// Datapath: phrase tables, load accumulator, search window and hop arithmetic.
// Depends on lzpra_pkg and lzpra_ram.
module lzpra_dp #(
    parameter int MaxPhrases = lzpra_pkg::MaxPhrases,
    parameter int PosBits    = lzpra_pkg::PosBits,
    parameter int MaxHops    = lzpra_pkg::MaxHops
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_length_mode,
    input  logic [1:0]                    i_cmd,
    input  logic [PosBits-1:0]            i_value,
    input  logic [PosBits-1:0]            i_source,
    input  logic [lzpra_pkg::CharBits-1:0] i_char,
    input  logic [PosBits-1:0]            i_qpos,
    input  lzpra_pkg::t_ctl               i_ctl,
    output lzpra_pkg::t_sts               o_sts,
    output logic [lzpra_pkg::CharBits-1:0] o_char,
    output logic [1:0]                    o_status,
    output logic [lzpra_pkg::HopBits-1:0] o_hops
);
    import lzpra_pkg::*;
    localparam int AW = $clog2(MaxPhrases);
    localparam int CW = AW + 1;

    logic [1:0]          r_cmd;
    logic [PosBits-1:0]  r_val, r_src;
    logic [CharBits-1:0] r_chr;
    logic [PosBits-1:0]  r_pos;
    logic [CW-1:0]       r_count;
    logic [PosBits-1:0]  r_run_end;
    logic [CW-1:0]       r_low, r_high, r_res, r_mid;
    logic                r_found;
    logic [HopBits-1:0]  r_hops;
    logic [PosBits-1:0]  r_this_end, r_prev_end, r_this_src;
    logic [CharBits-1:0] r_this_chr;
    logic [CharBits-1:0] r_ochar;
    logic [1:0]          r_ost;
    logic [HopBits-1:0]  r_ohops;

    logic [PosBits:0]    w_acc;
    logic [PosBits-1:0]  w_end_new;
    logic [CW-1:0]       w_mid;
    logic [AW-1:0]       w_raddr;
    logic [PosBits-1:0]  w_rd_end, w_rd_src;
    logic [CharBits-1:0] w_rd_chr;
    logic [PosBits:0]    w_target;
    logic                w_we;

    assign w_acc     = i_length_mode ? ({1'b0, r_run_end} + {1'b0, r_val}) : {1'b0, r_val};
    assign w_end_new = w_acc[PosBits-1:0];
    assign w_mid     = r_low + ((r_high - r_low) >> 1);
    assign w_we      = i_ctl.do_load;
    assign w_target  = {1'b0, r_this_src} + {1'b0, r_pos - r_prev_end};

    always_comb begin
        w_raddr = r_mid[AW-1:0];
        if (i_ctl.rd_res) begin
            w_raddr = r_res[AW-1:0];
        end else if (i_ctl.rd_prev) begin
            w_raddr = AW'(r_res - CW'(1));
        end else if (i_ctl.rd_mid) begin
            w_raddr = w_mid[AW-1:0];
        end
    end

    lzpra_ram #(.Width(PosBits), .Depth(MaxPhrases)) u_end (
        .i_clk, .i_we(w_we), .i_waddr(r_count[AW-1:0]), .i_wdata(w_end_new),
        .i_raddr(w_raddr), .o_rdata(w_rd_end));
    lzpra_ram #(.Width(PosBits), .Depth(MaxPhrases)) u_src (
        .i_clk, .i_we(w_we), .i_waddr(r_count[AW-1:0]), .i_wdata(r_src),
        .i_raddr(w_raddr), .o_rdata(w_rd_src));
    lzpra_ram #(.Width(CharBits), .Depth(MaxPhrases)) u_chr (
        .i_clk, .i_we(w_we), .i_waddr(r_count[AW-1:0]), .i_wdata(r_chr),
        .i_raddr(w_raddr), .o_rdata(w_rd_chr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_run_end <= '0;
        end else if (i_ctl.do_clear) begin
            r_count   <= '0;
            r_run_end <= '0;
        end else if (i_ctl.do_load) begin
            r_count   <= r_count + CW'(1);
            r_run_end <= w_end_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_in) begin
            r_cmd  <= i_cmd;
            r_val  <= i_value;
            r_src  <= i_source;
            r_chr  <= i_char;
            r_pos  <= i_qpos;
            r_hops <= '0;
        end
        if (i_ctl.srch_init) begin
            r_low   <= '0;
            r_high  <= r_count;
            r_res   <= '0;
            r_found <= 1'b0;
        end
        if (i_ctl.rd_mid) begin
            r_mid <= w_mid;
        end
        if (i_ctl.step_mid) begin
            if (w_rd_end <= r_pos) begin
                r_res   <= (w_rd_end == r_pos) ? r_mid : r_mid + CW'(1);
                r_found <= 1'b1;
                r_low   <= r_mid + CW'(1);
            end else begin
                r_high <= r_mid;
            end
        end
        if (i_ctl.cap_res) begin
            r_this_end <= w_rd_end;
            r_this_src <= w_rd_src;
            r_this_chr <= w_rd_chr;
            r_prev_end <= '0;
        end
        if (i_ctl.cap_prev) begin
            r_prev_end <= w_rd_end;
        end
        if (i_ctl.do_hop) begin
            r_pos  <= w_target[PosBits-1:0];
            r_hops <= r_hops + HopBits'(1);
        end
        if (i_ctl.set_out) begin
            r_ochar <= i_ctl.out_char ? r_this_chr : '0;
            r_ost   <= i_ctl.out_st;
            r_ohops <= i_ctl.out_hmax ? HopBits'(MaxHops) :
                       ((r_cmd == CMD_QUERY) ? r_hops : '0);
        end
    end

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.full      = (r_count >= CW'(MaxPhrases));
        o_sts.load_ovf  = w_acc[PosBits];
        o_sts.srch_more = (r_low < r_high);
        o_sts.found     = r_found;
        o_sts.res_valid = (r_res < r_count);
        o_sts.res_zero  = (r_res == '0);
        o_sts.hit       = (r_pos == r_this_end);
        o_sts.in_phrase = (r_pos > r_prev_end) && (r_pos < r_this_end);
        o_sts.hop_lim   = (r_hops >= HopBits'(MaxHops));
        o_sts.hop_ovf   = w_target[PosBits];
    end

    assign o_char   = r_ochar;
    assign o_status = r_ost;
    assign o_hops   = r_ohops;
endmodule

>>> hdl/lzpra_ctrl.sv
// Controller: sequences load, clear and the search/hop loop of a query.
// Depends on lzpra_pkg.
module lzpra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  lzpra_pkg::t_sts i_sts,
    output lzpra_pkg::t_ctl o_ctl
);
    import lzpra_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DEC   = 9'b000000010,
        S_SRCH  = 9'b000000100,
        S_RDWT  = 9'b000001000,
        S_STEP  = 9'b000010000,
        S_RES   = 9'b000100000,
        S_RESWT = 9'b001000000,
        S_EVAL  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.take_in = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                o_ctl.set_out = 1'b1;
                o_ctl.out_st  = ST_OK;
                n_state       = S_OUT;
                unique case (i_sts.cmd)
                    CMD_CLEAR: o_ctl.do_clear = 1'b1;
                    CMD_LOAD: begin
                        if (i_sts.full || i_sts.load_ovf) begin
                            o_ctl.out_st = ST_FULL;
                        end else begin
                            o_ctl.do_load = 1'b1;
                        end
                    end
                    CMD_QUERY: begin
                        o_ctl.set_out   = 1'b0;
                        o_ctl.srch_init = 1'b1;
                        n_state         = S_SRCH;
                    end
                    default: ;
                endcase
            end
            S_SRCH: begin
                if (i_sts.srch_more) begin
                    o_ctl.rd_mid = 1'b1;
                    n_state      = S_RDWT;
                end else if (!i_sts.found || !i_sts.res_valid) begin
                    o_ctl.set_out = 1'b1;
                    o_ctl.out_st  = ST_NOTFOUND;
                    n_state       = S_OUT;
                end else begin
                    o_ctl.rd_res = 1'b1;
                    n_state      = S_RES;
                end
            end
            S_RDWT: n_state = S_STEP;
            S_STEP: begin
                o_ctl.step_mid = 1'b1;
                n_state        = S_SRCH;
            end
            S_RES: begin
                // end/src/char of res are on the read port now; issue the prev read
                o_ctl.cap_res = 1'b1;
                o_ctl.rd_prev = 1'b1;
                n_state       = S_RESWT;
            end
            S_RESWT: begin
                o_ctl.cap_prev = !i_sts.res_zero;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_ctl.set_out = 1'b1;
                n_state       = S_OUT;
                if (i_sts.hit) begin
                    o_ctl.out_st   = ST_OK;
                    o_ctl.out_char = 1'b1;
                end else if (!i_sts.in_phrase) begin
                    o_ctl.out_st = ST_NOTFOUND;
                end else if (i_sts.hop_lim) begin
                    o_ctl.out_st   = ST_HOPLIM;
                    o_ctl.out_hmax = 1'b1;
                end else if (i_sts.hop_ovf) begin
                    o_ctl.out_st = ST_FULL;
                end else begin
                    o_ctl.set_out = 1'b0;
                    o_ctl.do_hop  = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> hdl/lz_phrase_random_access.sv
// Phrase table random access: one query or table command per transfer, one result each.
// Clear and load go from decode to the output handshake. A query runs a binary search over
// the end table through the single table read port, once at the start and once after each
// hop; the hop count is set by the data. Tables hold undefined data after reset; only
// entries below the phrase count are used.
module lz_phrase_random_access #(
    parameter int MaxPhrases = lzpra_pkg::MaxPhrases,
    parameter int PosBits    = lzpra_pkg::PosBits,
    parameter int MaxHops    = lzpra_pkg::MaxHops
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_length_mode_we,
    input  logic        i_length_mode,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // cmd
    input  logic [79:0] s_axis_tdata,   // phrase_value, phrase_source, phrase_char, query_pos
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tuser,   // [1:0] status
    output logic [23:0] m_axis_tdata    // result_char, hops
);
    import lzpra_pkg::*;

    logic   r_lmode;
    t_ctl   w_ctl;
    t_sts   w_sts;
    logic [CharBits-1:0] w_char;
    logic [1:0]          w_st;
    logic [HopBits-1:0]  w_hops;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lmode <= 1'b0;
        end else if (i_length_mode_we) begin
            r_lmode <= i_length_mode;
        end
    end

    lzpra_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(w_sts), .o_ctl(w_ctl));

    lzpra_dp #(.MaxPhrases(MaxPhrases), .PosBits(PosBits), .MaxHops(MaxHops)) u_dp (
        .i_clk, .i_rst_n,
        .i_length_mode(r_lmode),
        .i_cmd(s_axis_tuser),
        .i_value(PosBits'(s_axis_tdata[23:0])),
        .i_source(PosBits'(s_axis_tdata[47:24])),
        .i_char(s_axis_tdata[55:48]),
        .i_qpos(PosBits'(s_axis_tdata[79:56])),
        .i_ctl(w_ctl), .o_sts(w_sts),
        .o_char(w_char), .o_status(w_st), .o_hops(w_hops));

    assign m_axis_tdata = {w_hops, w_char};
    assign m_axis_tuser = {6'd0, w_st};
endmodule

>>> hdl/lzpra_chk.sv
// Port-level checker for the phrase random access block, bound to the top level.
// Depends on lz_phrase_random_access_macros.svh.
`include "lz_phrase_random_access_macros.svh"
module lzpra_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tuser,
    input logic [23:0] m_axis_tdata
);
    `LZPRA_ASSERT_IMPL(a_one_at_a_time, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready,
        "input taken while result pending")
    `LZPRA_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result dropped")
    `LZPRA_ASSERT_IMPL(a_char_only_ok, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser[1:0] != 2'd0), m_axis_tdata[7:0] == 8'd0,
        "char on failed query")
    `LZPRA_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[7:2] == 6'd0,
        "tuser pad bits set")
endmodule

bind lz_phrase_random_access lzpra_chk u_chk (.*);
